@@ rtl/gdbd_pkg.sv @@
// Shared types, widths and calendar tables for the Gregorian date difference core.
// No dependencies.
package gdbd_pkg;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 13;
  localparam int COUNT_W = 21;
  localparam int SER_W   = 22;
  localparam int QUO_W   = 11;
  localparam int CEN_W   = 7;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  // floor(q / 25) == (q * RECIP_25) >> RECIP_SHIFT for q < 2048
  localparam logic [SER_W-1:0] RECIP_25    = 22'd1311;
  localparam int               RECIP_SHIFT = 15;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef logic [DAY_W-1:0]   day_t;
  typedef logic [MONTH_W-1:0] month_t;
  typedef logic [YEAR_W-1:0]  year_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [SER_W-1:0]   serial_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } gdbd_adv_t;

  // days in month for a common year
  function automatic day_t month_len(input month_t m);
    day_t len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd31;
    endcase
    return len;
  endfunction

  // days before the first of the month in a common year
  function automatic logic [8:0] cum_days(input month_t m);
    logic [8:0] n;
    case (m)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

@@ rtl/gdbd_if.sv @@
// Valid/ready channel interfaces for date-pair items and day-count items.
// Depends on gdbd_pkg.
interface gdbd_in_if;
  import gdbd_pkg::*;

  logic   valid;
  logic   ready;
  day_t   start_day;
  month_t start_month;
  year_t  start_year;
  day_t   end_day;
  month_t end_month;
  year_t  end_year;
  logic   include_end;

  modport source (
    output valid, start_day, start_month, start_year,
    output end_day, end_month, end_year, include_end,
    input  ready
  );
  modport sink (
    input  valid, start_day, start_month, start_year,
    input  end_day, end_month, end_year, include_end,
    output ready
  );
endinterface

interface gdbd_out_if;
  import gdbd_pkg::*;

  logic   valid;
  logic   ready;
  count_t day_count;

  modport source (output valid, day_count, input ready);
  modport sink   (input valid, day_count, output ready);
endinterface

@@ rtl/gdbd_date_lane.sv @@
// Four-stage pipeline turning one clamped date into a serial day number.
// Depends on gdbd_pkg.
module gdbd_date_lane #(
  parameter int MAX_YEAR = 5000
) (
  input  logic               clk,
  input  gdbd_pkg::gdbd_adv_t adv,
  input  gdbd_pkg::day_t     day,
  input  gdbd_pkg::month_t   month,
  input  gdbd_pkg::year_t    year,
  output gdbd_pkg::serial_t  serial
);
  import gdbd_pkg::*;

  localparam int    YCAP = (MAX_YEAR > 8191) ? 8191 : MAX_YEAR;
  localparam year_t YMAX = YEAR_W'(YCAP);

  // stage 1: clamp
  year_t  y1_r, y1_nxt;
  month_t m1_r, m1_nxt;
  day_t   d1_r;

  always_comb begin
    if (year == '0) begin
      y1_nxt = year_t'(1);
    end else if (year > YMAX) begin
      y1_nxt = YMAX;
    end else begin
      y1_nxt = year;
    end
    if (month == '0) begin
      m1_nxt = MONTH_JAN;
    end else if (month > MONTH_DEC) begin
      m1_nxt = MONTH_DEC;
    end else begin
      m1_nxt = month;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      y1_r <= y1_nxt;
      m1_r <= m1_nxt;
      d1_r <= day;
    end
  end

  // stage 2: century quotients of y-1 and y
  year_t              p2_r, p2_nxt;
  logic [QUO_W-1:0]   qy2_r;
  logic [CEN_W-1:0]   cp2_r, cp2_nxt, cy2_r, cy2_nxt;
  logic [1:0]         ylo2_r;
  month_t             m2_r;
  day_t               d2_r;
  serial_t            prod_p, prod_y;

  always_comb begin
    p2_nxt  = y1_r - year_t'(1);
    prod_p  = SER_W'(p2_nxt[YEAR_W-1:2]) * RECIP_25;
    prod_y  = SER_W'(y1_r[YEAR_W-1:2]) * RECIP_25;
    cp2_nxt = prod_p[RECIP_SHIFT +: CEN_W];
    cy2_nxt = prod_y[RECIP_SHIFT +: CEN_W];
  end

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      p2_r   <= p2_nxt;
      qy2_r  <= y1_r[YEAR_W-1:2];
      cp2_r  <= cp2_nxt;
      cy2_r  <= cy2_nxt;
      ylo2_r <= y1_r[1:0];
      m2_r   <= m1_r;
      d2_r   <= d1_r;
    end
  end

  // stage 3: leap flag and days before the year
  serial_t          yb3_r, yb3_nxt;
  logic             leap3_r, leap3_nxt;
  logic [QUO_W-1:0] ry;
  month_t           m3_r;
  day_t             d3_r;

  always_comb begin
    ry        = qy2_r - (QUO_W'(cy2_r) * QUO_W'(25));
    leap3_nxt = (ylo2_r == 2'b00) && ((ry != '0) || (cy2_r[1:0] == 2'b00));
    yb3_nxt   = (SER_W'(p2_r) * SER_W'(365)) + SER_W'(p2_r[YEAR_W-1:2])
              - SER_W'(cp2_r) + SER_W'(cp2_r[CEN_W-1:2]);
  end

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      yb3_r   <= yb3_nxt;
      leap3_r <= leap3_nxt;
      m3_r    <= m2_r;
      d3_r    <= d2_r;
    end
  end

  // stage 4: month offset and clamped day
  serial_t ser4_r, ser4_nxt;
  day_t    dim, dc;
  logic    feb_extra;

  always_comb begin
    if (m3_r == MONTH_FEB) begin
      dim = leap3_r ? 5'd29 : 5'd28;
    end else begin
      dim = month_len(m3_r);
    end
    if (d3_r == '0) begin
      dc = day_t'(1);
    end else if (d3_r > dim) begin
      dc = dim;
    end else begin
      dc = d3_r;
    end
    feb_extra = leap3_r && (m3_r > MONTH_FEB);
    ser4_nxt  = yb3_r + SER_W'(cum_days(m3_r)) + SER_W'(feb_extra) + SER_W'(dc);
  end

  always_ff @(posedge clk) begin
    if (adv.s4) begin
      ser4_r <= ser4_nxt;
    end
  end

  assign serial = ser4_r;

endmodule

@@ rtl/gdbd_diff.sv @@
// Final stage: serial difference, include-end add and saturation into the output register.
// Depends on gdbd_pkg.
module gdbd_diff (
  input  logic                clk,
  input  gdbd_pkg::gdbd_adv_t adv,
  input  gdbd_pkg::serial_t   start_serial,
  input  gdbd_pkg::serial_t   end_serial,
  input  logic                include_end,
  output gdbd_pkg::count_t    day_count
);
  import gdbd_pkg::*;

  count_t            cnt_r, cnt_nxt;
  serial_t           diff;
  logic [SER_W:0]    sum;

  always_comb begin
    diff = (end_serial > start_serial) ? (end_serial - start_serial) : '0;
    sum  = {1'b0, diff} + (SER_W+1)'(include_end);
    if (sum > (SER_W+1)'(COUNT_MAX)) begin
      cnt_nxt = COUNT_MAX;
    end else begin
      cnt_nxt = sum[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s5) begin
      cnt_r <= cnt_nxt;
    end
  end

  assign day_count = cnt_r;

endmodule

@@ rtl/gregorian_days_between_dates_core.sv @@
// Top level of the Gregorian date difference core: pipeline control and two date lanes.
// Depends on gdbd_pkg, gdbd_if, gdbd_date_lane and gdbd_diff.
//
// Usage:
//   in_ch  (valid/ready sink) takes one item per cycle when ready: a start date, an end date
//          and an include-end flag. Out-of-range days, months and years are clamped.
//   out_ch (valid/ready source) returns one day_count item per input item, in order.
//   Five register stages: clamp, century quotients, leap/year base, serial day number,
//   difference. out_ch.valid rises once an accepted item reaches the difference register.
//   Throughput is one item per cycle while the receiver does not stall.
//   Reset clears every stage valid bit; the pipeline comes up empty and ready.
//   When the receiver stalls, the held result stays on out_ch and earlier stages
//   keep filling until every stage is occupied; in_ch.ready then drops. Each stage
//   advances when it is empty or the stage after it advances, so bubbles close up
//   and no item is dropped or repeated.
module gregorian_days_between_dates_core #(
  parameter int MAX_YEAR = 5000
) (
  input  logic       clk,
  input  logic       rst_n,
  gdbd_in_if.sink    in_ch,
  gdbd_out_if.source out_ch
);
  import gdbd_pkg::*;

  localparam int NSTG = 5;

  logic [NSTG-1:0] vld_r, vld_nxt;
  logic [NSTG-1:0] en;
  logic [3:0]      inc_r;
  gdbd_adv_t       adv;
  serial_t         ser_a, ser_b;

  always_comb begin
    en[NSTG-1] = !vld_r[NSTG-1] || out_ch.ready;
    for (int k = NSTG-2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
    vld_nxt[0] = en[0] ? in_ch.valid : vld_r[0];
    for (int k = 1; k < NSTG; k++) begin
      vld_nxt[k] = en[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) inc_r[0] <= in_ch.include_end;
    if (en[1]) inc_r[1] <= inc_r[0];
    if (en[2]) inc_r[2] <= inc_r[1];
    if (en[3]) inc_r[3] <= inc_r[2];
  end

  assign adv = '{s1: en[0], s2: en[1], s3: en[2], s4: en[3], s5: en[4]};

  gdbd_date_lane #(.MAX_YEAR(MAX_YEAR)) u_lane_start (
    .clk    (clk),
    .adv    (adv),
    .day    (in_ch.start_day),
    .month  (in_ch.start_month),
    .year   (in_ch.start_year),
    .serial (ser_a)
  );

  gdbd_date_lane #(.MAX_YEAR(MAX_YEAR)) u_lane_end (
    .clk    (clk),
    .adv    (adv),
    .day    (in_ch.end_day),
    .month  (in_ch.end_month),
    .year   (in_ch.end_year),
    .serial (ser_b)
  );

  gdbd_diff u_diff (
    .clk          (clk),
    .adv          (adv),
    .start_serial (ser_a),
    .end_serial   (ser_b),
    .include_end  (inc_r[3]),
    .day_count    (out_ch.day_count)
  );

  assign in_ch.ready  = en[0];
  assign out_ch.valid = vld_r[NSTG-1];

endmodule

@@ tb/gdbd_day_count_checker.sv @@
`timescale 1ns / 1ps
// Day-count checker for the Gregorian date difference core: predicts the count for
// every accepted date pair and compares returned counts with it in order.
// Depends on gdbd_pkg and the gdbd_in_if / gdbd_out_if channel interfaces.
module gdbd_day_count_checker #(
  parameter int unsigned MAX_YEAR = 5000
) (
  input  logic clk,
  input  logic rst_n,
  gdbd_in_if   in_ch,
  gdbd_out_if  out_ch,
  output int   errors,
  output int   pending,
  output int   checked
);
  import gdbd_pkg::*;

  localparam int unsigned COMMON_MONTH_DAYS [1:12] = '{31, 28, 31, 30, 31, 30,
                                                      31, 31, 30, 31, 30, 31};
  localparam int unsigned COUNT_LIMIT = (1 << COUNT_W) - 1;

  count_t expected_counts[$];
  count_t want;

  function automatic bit is_leap(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_days(input int unsigned y, input int unsigned m);
    if (m == 2 && is_leap(y)) return 29;
    return COMMON_MONTH_DAYS[m];
  endfunction

  // days since 1 Jan of year 1 (that day is 1), after clamping the date
  function automatic int unsigned day_number(input day_t d, input month_t m, input year_t y);
    int unsigned yy, mm, dd, prior, n;
    yy = y;
    mm = m;
    dd = d;
    if (yy < 1) yy = 1;
    if (yy > MAX_YEAR) yy = MAX_YEAR;
    if (mm < 1) mm = 1;
    if (mm > 12) mm = 12;
    if (dd < 1) dd = 1;
    if (dd > month_days(yy, mm)) dd = month_days(yy, mm);
    prior = yy - 1;
    n = prior * 365 + prior / 4 - prior / 100 + prior / 400;
    for (int unsigned i = 1; i < mm; i++) n += month_days(yy, i);
    return n + dd;
  endfunction

  function automatic count_t predict_day_count(
    input day_t sd, input month_t sm, input year_t sy,
    input day_t ed, input month_t em, input year_t ey, input logic inc
  );
    int unsigned a, b, c;
    a = day_number(sd, sm, sy);
    b = day_number(ed, em, ey);
    c = (b > a) ? b - a : 0;
    c += inc;
    if (c > COUNT_LIMIT) c = COUNT_LIMIT;
    return count_t'(c);
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        expected_counts.push_back(predict_day_count(in_ch.start_day, in_ch.start_month,
          in_ch.start_year, in_ch.end_day, in_ch.end_month, in_ch.end_year,
          in_ch.include_end));
      if (out_ch.valid && out_ch.ready) begin
        if (expected_counts.size() == 0) begin
          if (errors < 10)
            $display("%0t: unexpected day count %0d", $time, out_ch.day_count);
          errors++;
        end else begin
          want = expected_counts.pop_front();
          checked++;
          if (out_ch.day_count !== want) begin
            if (errors < 10)
              $display("%0t: day_count mismatch: expected %0d got %0d",
                       $time, want, out_ch.day_count);
            errors++;
          end
        end
      end
      pending = expected_counts.size();
    end
  end

endmodule

@@ tb/tb_gregorian_days_between_dates_core.sv @@
`timescale 1ns / 1ps
// Top of the Gregorian date difference testbench: clock, reset, date-pair stimulus
// with random idling on both channels, and the final verdict.
// Depends on gdbd_pkg, the channel interfaces, the core and gdbd_day_count_checker.
module tb_gregorian_days_between_dates_core;
  import gdbd_pkg::*;

  localparam int RANDOM_PAIRS = 600;
  localparam int unsigned EDGE_YEARS [11] = '{0, 1, 4, 100, 400, 1900, 2000,
                                             4999, 5000, 5001, 8191};
  localparam int unsigned EDGE_MONTHS [6] = '{0, 1, 2, 12, 13, 15};
  localparam int unsigned EDGE_DAYS [6]   = '{0, 1, 28, 29, 30, 31};

  logic clk = 1'b0;
  logic rst_n;
  logic calm;
  int   errors, pending, checked;
  int   sent;
  int   directed;

  gdbd_in_if  in_ch ();
  gdbd_out_if out_ch ();

  gregorian_days_between_dates_core #(.MAX_YEAR(5000)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  gdbd_day_count_checker #(.MAX_YEAR(5000)) u_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .errors  (errors),
    .pending (pending),
    .checked (checked)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #400000;
    $display("FAIL gregorian_days_between_dates_core");
    $finish;
  end

  // result side: stall with a chance of about 8 in 100, never while calm
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= rst_n && (calm || $urandom_range(99) >= 8);
    end
  end

  task automatic send_pair(input day_t sd, input month_t sm, input year_t sy,
                           input day_t ed, input month_t em, input year_t ey,
                           input logic inc);
    in_ch.start_day   <= sd;
    in_ch.start_month <= sm;
    in_ch.start_year  <= sy;
    in_ch.end_day     <= ed;
    in_ch.end_month   <= em;
    in_ch.end_year    <= ey;
    in_ch.include_end <= inc;
    in_ch.valid       <= 1'b1;
    do @(negedge clk); while (!in_ch.ready);
    @(posedge clk);
    sent++;
  endtask

  task automatic drain_counts();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic random_pair();
    int unsigned pick, sy, ey;
    day_t   sd, ed;
    month_t sm, em;
    pick = $urandom_range(99);
    sd = day_t'($urandom_range(1, 31));
    ed = day_t'($urandom_range(1, 31));
    sm = month_t'($urandom_range(1, 12));
    em = month_t'($urandom_range(1, 12));
    sy = $urandom_range(1, 5000);
    ey = $urandom_range(1, 5000);
    if (pick < 70 && pick >= 40) begin
      // close spans, either direction
      ey = sy + $urandom_range(4);
      ey = (ey >= 2) ? ey - 2 : 0;
      if ($urandom_range(1)) em = sm;
    end else if (pick < 85 && pick >= 70) begin
      sy = EDGE_YEARS[$urandom_range(10)];
      ey = EDGE_YEARS[$urandom_range(10)];
      sm = month_t'(EDGE_MONTHS[$urandom_range(5)]);
      em = month_t'(EDGE_MONTHS[$urandom_range(5)]);
      sd = day_t'(EDGE_DAYS[$urandom_range(5)]);
      ed = day_t'(EDGE_DAYS[$urandom_range(5)]);
    end else if (pick >= 85) begin
      sy = $urandom_range(8191);
      ey = $urandom_range(8191);
      sm = month_t'($urandom);
      em = month_t'($urandom);
      sd = day_t'($urandom);
      ed = day_t'($urandom);
    end
    send_pair(sd, sm, year_t'(sy), ed, em, year_t'(ey), logic'($urandom_range(1)));
  endtask

  initial begin
    rst_n             <= 1'b0;
    calm              <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.start_day   <= '0;
    in_ch.start_month <= '0;
    in_ch.start_year  <= '0;
    in_ch.end_day     <= '0;
    in_ch.end_month   <= '0;
    in_ch.end_year    <= '0;
    in_ch.include_end <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // edge cases
    send_pair(1, 1, 1, 1, 1, 1, 0);
    send_pair(1, 1, 1, 1, 1, 1, 1);
    send_pair(1, 1, 1, 31, 12, 5000, 1);
    send_pair(31, 12, 5000, 1, 1, 1, 1);
    send_pair(0, 0, 0, 0, 0, 0, 0);
    send_pair(31, 15, 8191, 31, 15, 8191, 1);
    send_pair(0, 0, 0, 31, 15, 8191, 0);
    send_pair(28, 2, 1900, 31, 2, 1900, 0);
    send_pair(28, 2, 2000, 31, 2, 2000, 0);
    send_pair(28, 2, 2004, 30, 2, 2004, 1);
    send_pair(31, 4, 2023, 1, 5, 2023, 0);
    send_pair(1, 12, 2020, 1, 13, 2020, 1);
    send_pair(1, 13, 2020, 31, 15, 2020, 0);
    send_pair(31, 12, 1999, 1, 1, 2000, 0);
    send_pair(1, 3, 2100, 1, 3, 2101, 0);
    send_pair(1, 3, 2399, 1, 3, 2400, 0);
    send_pair(1, 1, 4999, 1, 1, 5001, 0);
    send_pair(15, 6, 2500, 14, 6, 2500, 0);
    send_pair(1, 1, 0, 1, 1, 1, 0);
    send_pair(0, 1, 1, 2, 1, 1, 0);
    send_pair(29, 2, 5000, 1, 3, 5000, 1);
    directed = sent;
    drain_counts();

    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      if (i == 200) calm <= 1'b1;
      if (i == 400) calm <= 1'b0;
      if (i == 100 || i == 450) begin
        drain_counts();
      end else if (!calm && $urandom_range(99) < 8) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
      random_pair();
    end
    in_ch.valid <= 1'b0;

    for (int i = 0; i < 5000 && pending != 0; i++) @(negedge clk);
    repeat (20) @(posedge clk);
    if (pending != 0) $display("%0d day counts never returned", pending);

    $display("Sent %0d date pairs (%0d edge cases, rest random spans and raw fields),",
             sent, directed);
    $display("checked %0d day counts with idling on both channels", checked);
    if (errors + pending == 0) begin
      $display("PASS gregorian_days_between_dates_core");
    end else begin
      $display("FAIL gregorian_days_between_dates_core");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/gdbd_pkg.sv
rtl/gdbd_if.sv
rtl/gdbd_date_lane.sv
rtl/gdbd_diff.sv
rtl/gregorian_days_between_dates_core.sv
tb/gdbd_day_count_checker.sv
tb/tb_gregorian_days_between_dates_core.sv
